>>> hw/rtl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg: shared types and codes for the WebSocket frame deframer
// Field types, opcode and action codes, and the result record.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int LENGTH_BITS_DEF = 64;

  typedef logic [7:0] byte_t;
  typedef logic [6:0] opcode_t;

  localparam opcode_t OP_CONT  = 7'd0;
  localparam opcode_t OP_TEXT  = 7'd1;
  localparam opcode_t OP_BIN   = 7'd2;
  localparam opcode_t OP_CLOSE = 7'd8;
  localparam opcode_t OP_PING  = 7'd9;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_MSG   = 2'd1,
    ACT_PONG  = 2'd2,
    ACT_CLOSE = 2'd3
  } action_t;

  typedef struct packed {
    logic    kind;
    byte_t   payload_byte;
    opcode_t frame_opcode_out;
    logic    ctrl_frame;
    logic    fin_flag;
    logic    frame_end;
    action_t action;
  } res_t;

endpackage

>>> hw/rtl/wsd_ifs.sv
// ----------------------------------------------------------------------------
// wsd_ifs: channel interfaces of the WebSocket frame deframer
// Byte input channel and parsed result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface wsd_in_if import wsd_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsd_out_if import wsd_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    kind;
  byte_t   payload_byte;
  opcode_t frame_opcode_out;
  logic    ctrl_frame;
  logic    fin_flag;
  logic    frame_end;
  action_t action;

  modport source (output valid, output kind, output payload_byte, output frame_opcode_out,
                  output ctrl_frame, output fin_flag, output frame_end, output action,
                  input ready);
  modport sink   (input valid, input kind, input payload_byte, input frame_opcode_out,
                  input ctrl_frame, input fin_flag, input frame_end, input action,
                  output ready);
endinterface

>>> hw/rtl/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer: receive-side WebSocket frame parser
// Header parsing, payload unmasking and frame-end actions, one byte a cycle unless the receiver stalls.
// ----------------------------------------------------------------------------
// Usage:
//   in_bus carries the received connection stream, one byte per request.
//   out_bus carries at most one result per byte: an unmasked payload byte,
//   or an end marker for a frame with an empty payload, tagged with opcode,
//   control class, final flag, last-of-frame and the frame-end action.
//   Header bytes produce no result, except the one completing an empty frame.
//   After a close frame all further bytes are taken and dropped.
//   Throughput: one byte per cycle unless the receiver stalls, set by the
//   state update (phase, length counter decrement, key XOR) between the
//   input register and the result register.
//   Path: a byte accepted into the input register is parsed on its way into
//   the result register, from which its result is presented on out_bus.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   parser to the first header byte.
//   When the receiver stalls with a result waiting, the result register holds
//   and the parser stops, header bytes included; one more byte can sit in the
//   input register, after which in_bus.ready drops.
//   LENGTH_BITS sets the payload counter width; longer lengths saturate.
// ----------------------------------------------------------------------------
module websocket_frame_deframer import wsd_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  wsd_in_if.sink   in_bus,
  wsd_out_if.source out_bus
);

  logic  held_valid;
  byte_t held_byte;
  logic  can_load;
  logic  advance;
  logic  res_valid;
  res_t  res;
  res_t  out_res;

  assign advance = held_valid && can_load;

  wsd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_bus.valid),
    .in_ready   (in_bus.ready),
    .in_byte    (in_bus.rx_byte),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  wsd_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .rx_byte   (held_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  wsd_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .load_valid (res_valid),
    .load_res   (res),
    .can_load   (can_load),
    .out_valid  (out_bus.valid),
    .out_ready  (out_bus.ready),
    .out_res    (out_res)
  );

  assign out_bus.kind             = out_res.kind;
  assign out_bus.payload_byte     = out_res.payload_byte;
  assign out_bus.frame_opcode_out = out_res.frame_opcode_out;
  assign out_bus.ctrl_frame       = out_res.ctrl_frame;
  assign out_bus.fin_flag         = out_res.fin_flag;
  assign out_bus.frame_end        = out_res.frame_end;
  assign out_bus.action           = out_res.action;

endmodule

>>> hw/rtl/wsd_in_reg.sv
// ----------------------------------------------------------------------------
// wsd_in_reg: input byte register
// Holds one received byte until the parser can take it.
// ----------------------------------------------------------------------------
module wsd_in_reg import wsd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  byte_t in_byte,
  input  logic  advance,
  output logic  held_valid,
  output byte_t held_byte
);

  logic  valid_r, valid_nxt;
  byte_t byte_r;

  assign in_ready   = !valid_r || advance;
  assign held_valid = valid_r;
  assign held_byte  = byte_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
    end
  end

endmodule

>>> hw/rtl/wsd_parser.sv
// ----------------------------------------------------------------------------
// wsd_parser: frame header parser and payload unmasker
// Walks the header, collects length and key, unmasks payload bytes.
// ----------------------------------------------------------------------------
module wsd_parser import wsd_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step,
  input  byte_t rx_byte,
  output logic  res_valid,
  output res_t  res
);

  typedef enum logic [2:0] {
    PH_HDR0, PH_HDR1, PH_EXT, PH_KEY, PH_DATA, PH_CLOSED
  } phase_t;

  typedef logic [LENGTH_BITS-1:0] len_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  ext_left_r, ext_left_nxt;
  logic [2:0]  mask_left_r, mask_left_nxt;
  len_t        len_r, len_nxt;
  logic        ovf_r, ovf_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  idx_r, idx_nxt;
  opcode_t     op_r, op_nxt;
  logic        final_r, final_nxt;
  logic        masked_r, masked_nxt;

  logic        ctrl;
  action_t     fin_act;
  phase_t      fin_phase;
  len_t        len_sh;
  len_t        hd_len;
  logic        hd_ovf;
  logic        hd_go;
  logic [3:0]  ext_dec;
  logic [2:0]  mask_dec;
  logic [1:0]  idx_inv;
  byte_t       key_byte;

  assign ctrl = !(op_r == OP_CONT || op_r == OP_TEXT || op_r == OP_BIN);

  // frame-end action and the phase that follows it
  always_comb begin
    fin_phase = PH_HDR0;
    if (!ctrl) begin
      fin_act = final_r ? ACT_MSG : ACT_NONE;
    end else if (op_r == OP_CLOSE) begin
      fin_act   = ACT_CLOSE;
      fin_phase = PH_CLOSED;
    end else if (op_r == OP_PING) begin
      fin_act = ACT_PONG;
    end else begin
      fin_act = ACT_NONE;
    end
  end

  assign len_sh   = {len_r[LENGTH_BITS-9:0], rx_byte};
  assign ext_dec  = (ext_left_r != 4'd0) ? ext_left_r - 4'd1 : 4'd0;
  assign mask_dec = (mask_left_r != 3'd0) ? mask_left_r - 3'd1 : 3'd0;
  assign idx_inv  = 2'd3 - idx_r;
  assign key_byte = key_r[{idx_inv, 3'b000} +: 8];

  always_comb begin
    phase_nxt     = phase_r;
    ext_left_nxt  = ext_left_r;
    mask_left_nxt = mask_left_r;
    len_nxt       = len_r;
    ovf_nxt       = ovf_r;
    key_nxt       = key_r;
    idx_nxt       = idx_r;
    op_nxt        = op_r;
    final_nxt     = final_r;
    masked_nxt    = masked_r;
    hd_go         = 1'b0;
    hd_len        = len_r;
    hd_ovf        = ovf_r;
    res_valid     = 1'b0;
    res           = '0;
    res.frame_opcode_out = op_r;
    res.ctrl_frame       = ctrl;
    res.fin_flag         = final_r;
    res.action           = ACT_NONE;

    unique case (phase_r)
      PH_HDR0: begin
        final_nxt = rx_byte[7];
        op_nxt    = rx_byte[6:0];
        phase_nxt = PH_HDR1;
      end
      PH_HDR1: begin
        masked_nxt    = rx_byte[7];
        key_nxt       = '0;
        ovf_nxt       = 1'b0;
        mask_left_nxt = rx_byte[7] ? 3'd4 : 3'd0;
        if (rx_byte[6:0] == 7'd126) begin
          ext_left_nxt = 4'd2;
          len_nxt      = '0;
          phase_nxt    = PH_EXT;
        end else if (rx_byte[6:0] == 7'd127) begin
          ext_left_nxt = 4'd8;
          len_nxt      = '0;
          phase_nxt    = PH_EXT;
        end else begin
          ext_left_nxt = 4'd0;
          len_nxt      = len_t'(rx_byte[6:0]);
          if (rx_byte[7]) begin
            phase_nxt = PH_KEY;
          end else begin
            hd_go  = 1'b1;
            hd_len = len_t'(rx_byte[6:0]);
            hd_ovf = 1'b0;
          end
        end
      end
      PH_EXT: begin
        len_nxt      = len_sh;
        // bits shifted past the top of the counter mean saturation
        ovf_nxt      = ovf_r | (|len_r[LENGTH_BITS-1 -: 8]);
        ext_left_nxt = ext_dec;
        if (ext_dec == 4'd0) begin
          if (masked_r) begin
            phase_nxt = PH_KEY;
          end else begin
            hd_go  = 1'b1;
            hd_len = len_sh;
            hd_ovf = ovf_nxt;
          end
        end
      end
      PH_KEY: begin
        key_nxt       = {key_r[23:0], rx_byte};
        mask_left_nxt = mask_dec;
        if (mask_dec == 3'd0) begin
          hd_go = 1'b1;
        end
      end
      PH_DATA: begin
        res_valid        = 1'b1;
        res.kind         = KIND_DATA;
        res.payload_byte = masked_r ? (rx_byte ^ key_byte) : rx_byte;
        if (masked_r) begin
          idx_nxt = idx_r + 2'd1;
        end
        len_nxt = (len_r != '0) ? len_r - len_t'(1) : '0;
        if (len_r <= len_t'(1)) begin
          res.frame_end = 1'b1;
          res.action    = fin_act;
          phase_nxt     = fin_phase;
        end
      end
      PH_CLOSED: begin
      end
      default: begin
        phase_nxt = PH_HDR0;
      end
    endcase

    // header complete: start payload or mark an empty frame
    if (hd_go) begin
      idx_nxt = 2'd0;
      if (hd_ovf) begin
        len_nxt   = '1;
        phase_nxt = PH_DATA;
      end else if (hd_len == '0) begin
        len_nxt       = '0;
        res_valid     = 1'b1;
        res.kind      = KIND_END;
        res.frame_end = 1'b1;
        res.action    = fin_act;
        phase_nxt     = fin_phase;
      end else begin
        len_nxt   = hd_len;
        phase_nxt = PH_DATA;
      end
    end

    if (!step) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR0;
      ext_left_r  <= '0;
      mask_left_r <= '0;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      key_r       <= '0;
      idx_r       <= '0;
      op_r        <= '0;
      final_r     <= 1'b0;
      masked_r    <= 1'b0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      ext_left_r  <= ext_left_nxt;
      mask_left_r <= mask_left_nxt;
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      key_r       <= key_nxt;
      idx_r       <= idx_nxt;
      op_r        <= op_nxt;
      final_r     <= final_nxt;
      masked_r    <= masked_nxt;
    end
  end

endmodule

>>> hw/rtl/wsd_out_reg.sv
// ----------------------------------------------------------------------------
// wsd_out_reg: result register
// Holds one parsed result until the receiver takes it.
// ----------------------------------------------------------------------------
module wsd_out_reg import wsd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  logic load_valid,
  input  res_t load_res,
  output logic can_load,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic valid_r, valid_nxt;
  res_t res_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (can_load) begin
      valid_nxt = load && load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (can_load && load && load_valid) begin
      res_r <= load_res;
    end
  end

endmodule
